// File: sv/lcg_draw_candidate_check_top_defines.svh
// assertion macros for the lcg draw candidate check block
// used by lcg_draw_candidate_check_top, expects clk and arst_n in scope
`ifndef LCG_DRAW_CANDIDATE_CHECK_TOP_DEFINES_SVH
`define LCG_DRAW_CANDIDATE_CHECK_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LCGC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LCGC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCGC_ASSERT_IMPL(name, ante, cons, msg)
`define LCGC_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: sv/lcgc_pkg.sv
// shared constants and types for the lcg draw candidate check block
// no dependencies
package lcgc_pkg;

	localparam int POOL_SIZE      = 80;
	localparam int DRAW_COUNT     = 20;
	localparam int KNOWN_LOW_BITS = 21;

	localparam int STATE_W     = 48;
	localparam int HIGH_W      = 27;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	localparam int LCG_MUL_W = 35;
	localparam logic [LCG_MUL_W-1:0] LCG_MUL = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0]   LCG_ADD = 48'hB;
	localparam int DRAW_SHIFT = 17;

	localparam int MUL_HALF   = STATE_W / 2;
	localparam int MUL_PHASES = 3;
	localparam logic [MUL_HALF-1:0] LCG_ML = LCG_MUL[MUL_HALF-1:0];
	localparam logic [MUL_HALF-1:0] LCG_MH = MUL_HALF'(LCG_MUL >> MUL_HALF);

	localparam int TOP_W      = STATE_W - DRAW_SHIFT;
	localparam int DIV_BITS   = 8;
	localparam int DIV_CHUNKS = (TOP_W + DIV_BITS - 1) / DIV_BITS;
	localparam int TOP_PAD_W  = DIV_CHUNKS * DIV_BITS;

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int VAL_W = $clog2(POOL_SIZE + 1);
	localparam int K_W   = $clog2(DRAW_COUNT + 1);
	localparam int CNT_W = $clog2((DIV_CHUNKS > MUL_PHASES) ? DIV_CHUNKS : MUL_PHASES);

	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 64;
	localparam int TGT_LOW_W  = 64;
	localparam int TGT_HIGH_W = 16;

	localparam logic [CFG_AW-1:0] CFG_LOW_STATE   = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_TARGET_LOW  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_TARGET_HIGH = 2'd2;

	// multiplier passes: low x low, high x low, low x high
	localparam logic [CNT_W-1:0] MUL_LL = 2'd0;
	localparam logic [CNT_W-1:0] MUL_HL = 2'd1;
	localparam logic [CNT_W-1:0] MUL_LH = 2'd2;

	typedef struct packed {
		logic             load;
		logic             mul_en;
		logic [CNT_W-1:0] cnt;
		logic             div_en;
		logic             div_first;
		logic             div_last;
		logic             chk;
	} lcgc_cmd_t;

	typedef struct packed {
		logic miss;
		logic last_draw;
	} lcgc_sts_t;

	typedef struct packed {
		logic [STATE_W-1:0] full_state;
		logic [K_W-1:0]     depth;
		logic               matched;
	} lcgc_res_t;

endpackage

// File: sv/lcg_draw_candidate_check_top.sv
// lcg draw candidate check, top level: controller, datapath and output register
// each item examines 1 to 20 draws, stopping at the first draw outside the target set
// each draw: 3 passes of the shared 24x24 multiplier, chunked remainder, ram read, check
// one item at a time; the next item is accepted only after the previous result is loaded
// reset clears config registers to zero and all control state; no clearing pass
`include "lcg_draw_candidate_check_top_defines.svh"
module lcg_draw_candidate_check_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lcgc_pkg::IN_TDATA_W-1:0]     s_tdata,   // high_state_bits
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lcgc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // matched, reject_depth, full_state
	input  logic                                cfg_we,
	input  logic [lcgc_pkg::CFG_AW-1:0]         cfg_addr,
	input  logic [lcgc_pkg::CFG_DW-1:0]         cfg_wdata
);

	lcgc_pkg::lcgc_cmd_t cmd;
	lcgc_pkg::lcgc_sts_t sts;
	lcgc_pkg::lcgc_res_t res;

	logic                             out_free;
	logic                             out_load;
	logic                             m_tvalid_q;
	logic [lcgc_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;

	lcgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.ready    (s_tready),
		.out_load (out_load)
	);

	lcgc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_high   (s_tdata[lcgc_pkg::HIGH_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= lcgc_pkg::OUT_TDATA_W'(res);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`LCGC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item accepted while busy")
	`LCGC_ASSERT_IMPL(a_no_overwrite, out_load, !m_tvalid || m_tready, "result overwritten")
	`LCGC_ASSERT_IMPL(a_match_depth, m_tvalid, m_tdata[0] == (m_tdata[5:1] == lcgc_pkg::K_W'(lcgc_pkg::DRAW_COUNT)), "match flag and depth disagree")

endmodule

// File: sv/lcgc_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module lcgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         ra_data,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

// File: sv/lcgc_dp.sv
// datapath: config registers, lcg state, shared multiplier, remainder unit, permutation
// depends on lcgc_pkg and lcgc_ram
module lcgc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcgc_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [lcgc_pkg::CFG_DW-1:0]      cfg_wdata,
	input  logic [lcgc_pkg::HIGH_W-1:0]      in_high,
	input  lcgc_pkg::lcgc_cmd_t              cmd,
	output lcgc_pkg::lcgc_sts_t              sts,
	output lcgc_pkg::lcgc_res_t              res
);

	logic [lcgc_pkg::KNOWN_LOW_BITS-1:0] low_bits_q;
	logic [lcgc_pkg::TGT_LOW_W-1:0]      tgt_low_q;
	logic [lcgc_pkg::TGT_HIGH_W-1:0]     tgt_high_q;

	logic [lcgc_pkg::STATE_W-1:0]   s_q;
	logic [lcgc_pkg::STATE_W-1:0]   acc_q;
	logic [lcgc_pkg::STATE_W-1:0]   start_q;
	logic [lcgc_pkg::K_W-1:0]       k_q;
	logic [lcgc_pkg::TOP_PAD_W-1:0] div_sh_q;
	logic [lcgc_pkg::IDX_W-1:0]     rem_q;
	logic [lcgc_pkg::IDX_W-1:0]     j_q;
	logic [lcgc_pkg::POOL_SIZE-1:0] vld_q;
	logic [lcgc_pkg::K_W-1:0]       depth_q;
	logic                           matched_q;

	logic [lcgc_pkg::STATE_W-1:0]   start;
	logic [lcgc_pkg::MUL_HALF-1:0]  mul_a;
	logic [lcgc_pkg::MUL_HALF-1:0]  mul_b;
	logic [lcgc_pkg::STATE_W-1:0]   prod;
	logic [lcgc_pkg::STATE_W-1:0]   prod_sh;
	logic [lcgc_pkg::VAL_W-1:0]     span;
	logic [lcgc_pkg::TOP_PAD_W-1:0] div_src;
	logic [lcgc_pkg::IDX_W-1:0]     rem_nxt;
	logic [lcgc_pkg::IDX_W:0]       trial;
	logic [lcgc_pkg::IDX_W-1:0]     j_nxt;
	logic [lcgc_pkg::IDX_W-1:0]     k_idx;
	logic [lcgc_pkg::VAL_W-1:0]     ram_j;
	logic [lcgc_pkg::VAL_W-1:0]     ram_k;
	logic [lcgc_pkg::VAL_W-1:0]     val_j;
	logic [lcgc_pkg::VAL_W-1:0]     val_k;
	logic [lcgc_pkg::POOL_SIZE-1:0] tgt;
	logic [lcgc_pkg::IDX_W-1:0]     tgt_idx;
	logic                           finish;

	assign start = lcgc_pkg::STATE_W'({in_high, low_bits_q});

	// mod 2^48 product from three 24x24 passes
	assign mul_a   = (cmd.cnt == lcgc_pkg::MUL_HL) ? s_q[lcgc_pkg::STATE_W-1:lcgc_pkg::MUL_HALF]
	                                               : s_q[lcgc_pkg::MUL_HALF-1:0];
	assign mul_b   = (cmd.cnt == lcgc_pkg::MUL_LH) ? lcgc_pkg::LCG_MH : lcgc_pkg::LCG_ML;
	assign prod    = mul_a * mul_b;
	assign prod_sh = {prod[lcgc_pkg::MUL_HALF-1:0], {lcgc_pkg::MUL_HALF{1'b0}}};

	// remainder of (s >> 17) by span, one chunk of bits per cycle
	assign span    = lcgc_pkg::VAL_W'(lcgc_pkg::POOL_SIZE) - lcgc_pkg::VAL_W'(k_q);
	assign div_src = cmd.div_first
	               ? lcgc_pkg::TOP_PAD_W'(s_q[lcgc_pkg::STATE_W-1:lcgc_pkg::DRAW_SHIFT])
	               : div_sh_q;

	always_comb begin
		rem_nxt = cmd.div_first ? '0 : rem_q;
		trial   = '0;
		for (int i = 0; i < lcgc_pkg::DIV_BITS; i++) begin
			trial = {rem_nxt, div_src[lcgc_pkg::TOP_PAD_W-1-i]};
			if (trial >= (lcgc_pkg::IDX_W+1)'(span)) begin
				trial = trial - (lcgc_pkg::IDX_W+1)'(span);
			end
			rem_nxt = trial[lcgc_pkg::IDX_W-1:0];
		end
	end

	assign j_nxt = lcgc_pkg::IDX_W'(k_q) + rem_nxt;
	assign k_idx = lcgc_pkg::IDX_W'(k_q);

	lcgc_ram #(
		.WIDTH (lcgc_pkg::VAL_W),
		.DEPTH (lcgc_pkg::POOL_SIZE)
	) u_perm (
		.clk     (clk),
		.we      (cmd.chk),
		.waddr   (j_q),
		.wdata   (val_k),
		.ra_addr (j_q),
		.rb_addr (k_idx),
		.ra_data (ram_j),
		.rb_data (ram_k)
	);

	// entries not yet written hold the identity value
	assign val_j = vld_q[j_q]   ? ram_j : lcgc_pkg::VAL_W'(j_q) + lcgc_pkg::VAL_W'(1);
	assign val_k = vld_q[k_idx] ? ram_k : lcgc_pkg::VAL_W'(k_idx) + lcgc_pkg::VAL_W'(1);

	assign tgt     = {tgt_high_q, tgt_low_q};
	assign tgt_idx = lcgc_pkg::IDX_W'(val_j - lcgc_pkg::VAL_W'(1));

	assign sts.miss      = !tgt[tgt_idx];
	assign sts.last_draw = (k_q == lcgc_pkg::K_W'(lcgc_pkg::DRAW_COUNT - 1));
	assign finish        = sts.miss || sts.last_draw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bits_q <= '0;
			tgt_low_q  <= '0;
			tgt_high_q <= '0;
			k_q        <= '0;
			vld_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					lcgc_pkg::CFG_LOW_STATE: begin
						low_bits_q <= cfg_wdata[lcgc_pkg::KNOWN_LOW_BITS-1:0];
					end
					lcgc_pkg::CFG_TARGET_LOW: begin
						tgt_low_q <= cfg_wdata[lcgc_pkg::TGT_LOW_W-1:0];
					end
					lcgc_pkg::CFG_TARGET_HIGH: begin
						tgt_high_q <= cfg_wdata[lcgc_pkg::TGT_HIGH_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				k_q   <= '0;
				vld_q <= '0;
			end else if (cmd.chk) begin
				vld_q[j_q] <= 1'b1;
				if (!finish) begin
					k_q <= k_q + lcgc_pkg::K_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q     <= start;
			start_q <= start;
		end else if (cmd.mul_en) begin
			case (cmd.cnt)
				lcgc_pkg::MUL_LL: acc_q <= prod;
				lcgc_pkg::MUL_HL: acc_q <= acc_q + prod_sh;
				default:          s_q   <= acc_q + prod_sh + lcgc_pkg::LCG_ADD;
			endcase
		end
		if (cmd.div_en) begin
			div_sh_q <= div_src << lcgc_pkg::DIV_BITS;
			rem_q    <= rem_nxt;
			if (cmd.div_last) begin
				j_q <= j_nxt;
			end
		end
		if (cmd.chk && finish) begin
			depth_q   <= sts.miss ? k_q : lcgc_pkg::K_W'(lcgc_pkg::DRAW_COUNT);
			matched_q <= !sts.miss;
		end
	end

	assign res.full_state = start_q;
	assign res.depth      = depth_q;
	assign res.matched    = matched_q;

endmodule

// File: sv/lcgc_ctrl.sv
// controller: sequences multiply, remainder, read and check steps for each draw
// depends on lcgc_pkg
module lcgc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  lcgc_pkg::lcgc_sts_t sts,
	output lcgc_pkg::lcgc_cmd_t cmd,
	output logic                ready,
	output logic                out_load
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_RD,
		ST_CHK,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic [lcgc_pkg::CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == lcgc_pkg::CNT_W'(lcgc_pkg::MUL_PHASES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + lcgc_pkg::CNT_W'(1);
					end
				end
				ST_DIV: begin
					if (cnt_q == lcgc_pkg::CNT_W'(lcgc_pkg::DIV_CHUNKS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_RD;
					end else begin
						cnt_q <= cnt_q + lcgc_pkg::CNT_W'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cnt_q <= '0;
					if (sts.miss || sts.last_draw) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready    = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FIN) && out_free;

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.cnt       = cnt_q;
		cmd.div_en    = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.div_last  = (state_q == ST_DIV)
		             && (cnt_q == lcgc_pkg::CNT_W'(lcgc_pkg::DIV_CHUNKS - 1));
		cmd.chk       = (state_q == ST_CHK);
	end

endmodule

// File: tb/tb_top.sv
// testbench for lcg_draw_candidate_check_top: directed and random candidate states, checked
// against an in-bench shuffle predictor; depends on lcgc_pkg and the block's rtl only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL       = 80;
	localparam int DRAWS      = 20;
	localparam int LOW_BITS   = 21;
	localparam int STALL_LIMIT = 4000;
	localparam logic [47:0] LCG_FACTOR = 48'h5DEECE66D;
	localparam logic [47:0] LCG_INC    = 48'hB;
	localparam logic [lcgc_pkg::CFG_AW-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        matched;
		logic [4:0]  depth;
		logic [47:0] full_state;
	} verdict_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [lcgc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [lcgc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_we = 1'b0;
	logic [lcgc_pkg::CFG_AW-1:0]      cfg_addr = '0;
	logic [lcgc_pkg::CFG_DW-1:0]      cfg_wdata = '0;

	logic [20:0] cur_low = '0;
	logic [63:0] cur_tgt_lo = '0;
	logic [15:0] cur_tgt_hi = '0;

	verdict_t expected_verdicts[$];
	verdict_t head_verdict;
	int errors = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit idle_en = 1'b1;

	lcg_draw_candidate_check_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// partial shuffle from a start state; returns the set of numbers drawn before stopping
	function automatic logic [79:0] shuffle_draws(input logic [47:0] start,
			input logic [79:0] tgt, output logic [4:0] depth);
		logic [6:0]  perm [POOL];
		logic [47:0] s;
		logic [30:0] top;
		logic [6:0]  t;
		logic [79:0] drawn;
		int j;
		for (int i = 0; i < POOL; i++) perm[i] = 7'(i + 1);
		s = start;
		depth = 5'(DRAWS);
		drawn = '0;
		for (int k = 0; k < DRAWS; k++) begin
			s = s * LCG_FACTOR + LCG_INC;
			top = s[47:17];
			j = k + int'(top % 31'(POOL - k));
			t = perm[k];
			perm[k] = perm[j];
			perm[j] = t;
			drawn[perm[k] - 1] = 1'b1;
			if (!tgt[perm[k] - 1]) begin
				depth = 5'(k);
				break;
			end
		end
		return drawn;
	endfunction

	function automatic verdict_t predict_verdict(input logic [26:0] hi);
		verdict_t v;
		logic [4:0] d;
		logic [79:0] unused_drawn;
		v.full_state = {hi, cur_low};
		unused_drawn = shuffle_draws(v.full_state, {cur_tgt_hi, cur_tgt_lo}, d);
		v.depth = d;
		v.matched = (d == 5'(DRAWS));
		return v;
	endfunction

	function automatic logic [79:0] rand_set(input int pct);
		logic [79:0] r;
		for (int i = 0; i < POOL; i++) r[i] = (int'($urandom_range(99)) < pct);
		return r;
	endfunction

	task automatic note_error(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %h got %h at %0t", what, exp_v, act_v, $realtime);
	endtask

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic offer_candidate(input logic [26:0] hi);
		while (idle_en && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, hi};
		do @(posedge clk); while (!s_tready);
		expected_verdicts.push_back(predict_verdict(hi));
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [lcgc_pkg::CFG_AW-1:0] addr, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		case (addr)
			lcgc_pkg::CFG_LOW_STATE:   cur_low = data[20:0];
			lcgc_pkg::CFG_TARGET_LOW:  cur_tgt_lo = data;
			lcgc_pkg::CFG_TARGET_HIGH: cur_tgt_hi = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_targets(input logic [79:0] tset);
		cfg_write(lcgc_pkg::CFG_TARGET_LOW, tset[63:0]);
		cfg_write(lcgc_pkg::CFG_TARGET_HIGH,
			{48'($urandom) << 16, tset[79:64]} | 64'(tset[79:64]));
	endtask

	task automatic set_low(input logic [20:0] low);
		cfg_write(lcgc_pkg::CFG_LOW_STATE, {43'({$urandom, $urandom}), low});
	endtask

	// registers at reset: empty target set, every candidate misses on the first draw
	task automatic test_reset_defaults;
		offer_candidate('0);
		offer_candidate('1);
		drain();
	endtask

	task automatic test_state_assembly;
		cfg_write(lcgc_pkg::CFG_TARGET_LOW, '1);
		cfg_write(lcgc_pkg::CFG_TARGET_HIGH, '1);
		cfg_write(lcgc_pkg::CFG_LOW_STATE, '1);
		offer_candidate('0);
		offer_candidate('1);
		offer_candidate(27'h5555555);
		offer_candidate(27'h2AAAAAA);
		drain();
		set_low('0);
		offer_candidate('1);
		offer_candidate('0);
		drain();
		set_low(21'h0AAAAA);
		offer_candidate(27'h5555555);
		drain();
	endtask

	// write to the unused index must leave the full target set in place
	task automatic test_unknown_register;
		cfg_write(CFG_UNUSED, '0);
		offer_candidate(27'($urandom));
		drain();
	endtask

	task automatic test_exact_draw;
		logic [26:0] seed_hi;
		logic [79:0] drawn;
		logic [4:0]  d;
		int v;
		seed_hi = 27'($urandom);
		set_low(21'($urandom));
		drawn = shuffle_draws({seed_hi, cur_low}, '1, d);
		set_targets(drawn);
		offer_candidate(seed_hi);
		offer_candidate(27'($urandom));
		offer_candidate(seed_hi ^ 27'(1 << $urandom_range(26)));
		drain();
		do v = $urandom_range(POOL - 1); while (!drawn[v]);
		drawn[v] = 1'b0;
		set_targets(drawn);
		offer_candidate(seed_hi);
		offer_candidate(27'($urandom));
		drain();
	endtask

	task automatic test_random_candidates;
		logic [26:0] seed_hi;
		logic [79:0] tset;
		logic [4:0]  d;
		int mode;
		for (int ph = 0; ph < 15; ph++) begin
			idle_en = !(ph == 6 || ph == 7);
			case ($urandom_range(4))
				0: set_low('0);
				1: set_low('1);
				default: set_low(21'($urandom));
			endcase
			mode = $urandom_range(4);
			seed_hi = 27'($urandom);
			case (mode)
				0: tset = '1;
				1: tset = rand_set($urandom_range(98, 85));
				2: tset = rand_set($urandom_range(80, 50));
				3: tset = shuffle_draws({seed_hi, cur_low}, '1, d) | rand_set(5);
				default: tset = rand_set($urandom_range(10));
			endcase
			set_targets(tset);
			repeat (58) begin
				if (mode == 3 && $urandom_range(2) == 0)
					offer_candidate(seed_hi);
				else
					offer_candidate(27'($urandom));
			end
			drain();
		end
		idle_en = 1'b1;
	endtask

	// receiver holds off while items keep coming, so the input side must stall
	task automatic test_output_stall;
		set_targets(rand_set(95));
		@(posedge clk);
		hold_left = 500;
		@(negedge clk);
		repeat (40) offer_candidate(27'($urandom));
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_en && $urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				note_error("result with nothing pending", '0, 64'(m_tdata));
			end else begin
				head_verdict = expected_verdicts.pop_front();
				if (m_tdata[0] !== head_verdict.matched)
					note_error("matched", 64'(head_verdict.matched), 64'(m_tdata[0]));
				if (m_tdata[5:1] !== head_verdict.depth)
					note_error("reject_depth", 64'(head_verdict.depth), 64'(m_tdata[5:1]));
				if (m_tdata[53:6] !== head_verdict.full_state)
					note_error("full_state", 64'(head_verdict.full_state), 64'(m_tdata[53:6]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_state_assembly();
		test_unknown_register();
		test_exact_draw();
		test_random_candidates();
		test_output_stall();
		drain();
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: lcg_draw_candidate_check_top.f
+incdir+sv
sv/lcgc_pkg.sv
sv/lcgc_ram.sv
sv/lcgc_dp.sv
sv/lcgc_ctrl.sv
sv/lcg_draw_candidate_check_top.sv
tb/tb_top.sv
